### design/lare_pkg.sv
`default_nettype none
package lare_pkg;

   localparam int ENV_ONE        = 65536;
   localparam int RELEASE_CUTOFF = 66;
   localparam int ATTACK_SNAP    = 328;
   localparam int STEP_RESET     = 7;

   // multiplier bits scanned per pass, most significant first
   localparam int ENV_BITS  = 17;
   localparam int WAVE_BITS = 16;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET_AMP = 2'd1,
      OP_STOP = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_ATTACK_STEP = 2'd0,
      REG_RELEASE_STEP = 2'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_ENV,
      ST_MUL_WAVE,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### design/linear_attack_release_envelope_unit.sv
// Linear attack/release envelope gate for one voice. Set-amplitude and stop
// transactions update the envelope state in the cycle they are accepted and
// give no result; the block is ready again on the next cycle. An accepted tick
// has its product amplitude * envelope * sample formed by a shift-add
// multiplier that scans one multiplier bit per cycle: first the 17 envelope
// bits, then the 16 sample bits, then the result is loaded into the output
// register; no new transaction is accepted until that load. The load waits,
// and the block stays busy, for as long as the previous result still sits
// unaccepted in the output register. A finished result waits in the output
// register while the next transaction is accepted. Step registers are
// written through the csr port (index 0 attack step, index 1 release step);
// the user must write them only while the block is idle, which the block
// itself does not enforce. Values above 65536 are clamped to 65536.
`default_nettype none
module linear_attack_release_envelope_unit (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire  [1:0]        req_opcode,
   input  wire  signed [15:0] req_amplitude_value,
   input  wire  signed [15:0] req_wave_sample,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [15:0] rsp_audio_out,
   output logic              rsp_voice_active,
   input  wire               csr_write_enable,
   input  wire  [1:0]        csr_index,
   input  wire  [16:0]       csr_write_data
);

   localparam logic [16:0] EnvOne = 17'(lare_pkg::ENV_ONE);

   lare_pkg::state_type state_ff, state_in;

   logic [16:0]        attack_step_ff, attack_step_in;
   logic [16:0]        release_step_ff, release_step_in;
   logic signed [15:0] amplitude_ff, amplitude_in;
   logic [16:0]        attack_level_ff, attack_level_in;
   logic [16:0]        release_level_ff, release_level_in;

   logic [4:0]         count_ff, count_in;
   logic signed [47:0] acc_ff, acc_in;
   logic [30:0]        mcand_ff, mcand_in;
   logic [16:0]        mplier_ff, mplier_in;
   logic signed [15:0] wave_ff, wave_in;
   logic               active_ff, active_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] audio_ff, audio_in;
   logic               voice_ff, voice_in;

   logic               accept;
   logic               out_free;
   logic               amp_positive;
   logic signed [17:0] release_diff;
   logic signed [17:0] attack_diff;
   logic [16:0]        attack_next;
   logic [16:0]        tick_env;
   logic [14:0]        tick_amp;
   logic signed [47:0] addend;
   logic signed [47:0] acc_step;
   logic signed [16:0] quotient;
   logic [16:0]        csr_clamped;

   assign accept       = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign amp_positive = !amplitude_ff[15] && (amplitude_ff != 16'sd0);
   assign release_diff = $signed({1'b0, release_level_ff}) - $signed({1'b0, release_step_ff});
   assign attack_diff  = $signed({1'b0, attack_level_ff}) - $signed({1'b0, attack_step_ff});
   assign attack_next  = (attack_diff <= $signed(18'(lare_pkg::ATTACK_SNAP)))
                         ? 17'd0 : attack_diff[16:0];
   assign csr_clamped  = (csr_write_data > EnvOne) ? EnvOne : csr_write_data;

   // one shift-add step; the sample's sign bit carries negative weight
   assign addend   = mplier_ff[16] ? $signed({17'd0, mcand_ff}) : 48'sd0;
   assign acc_step = $signed({acc_ff[46:0], 1'b0})
                   + (((state_ff == lare_pkg::ST_MUL_WAVE) && (count_ff == 5'd0))
                      ? -addend : addend);
   // floor shift right by 31
   assign quotient = acc_ff[47:31];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lare_pkg::ST_IDLE: begin
            if (accept && (req_opcode == lare_pkg::OP_TICK)) state_in = lare_pkg::ST_MUL_ENV;
         end
         lare_pkg::ST_MUL_ENV: begin
            if (count_ff == 5'(lare_pkg::ENV_BITS - 1)) state_in = lare_pkg::ST_MUL_WAVE;
         end
         lare_pkg::ST_MUL_WAVE: begin
            if (count_ff == 5'(lare_pkg::WAVE_BITS - 1)) state_in = lare_pkg::ST_DONE;
         end
         lare_pkg::ST_DONE: begin
            if (out_free) state_in = lare_pkg::ST_IDLE;
         end
         default: state_in = lare_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = (state_ff == lare_pkg::ST_IDLE);
      rsp_valid        = rsp_valid_ff;
      rsp_audio_out    = audio_ff;
      rsp_voice_active = voice_ff;
   end

   // tick envelope and multiplicand, taken from the state before the tick
   always_comb begin
      tick_env = 17'd0;
      tick_amp = 15'd0;
      if (amp_positive) begin
         tick_amp = amplitude_ff[14:0];
         tick_env = (release_level_ff != 17'd0) ? release_level_ff : EnvOne - attack_next;
      end
   end

   // envelope state, configuration and datapath
   always_comb begin
      attack_step_in   = attack_step_ff;
      release_step_in  = release_step_ff;
      amplitude_in     = amplitude_ff;
      attack_level_in  = attack_level_ff;
      release_level_in = release_level_ff;
      count_in         = count_ff;
      acc_in           = acc_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      wave_in          = wave_ff;
      active_in        = active_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      audio_in         = audio_ff;
      voice_in         = voice_ff;

      if (csr_write_enable) begin
         case (csr_index)
            lare_pkg::REG_ATTACK_STEP:  attack_step_in = csr_clamped;
            lare_pkg::REG_RELEASE_STEP: release_step_in = csr_clamped;
            default: ;
         endcase
      end

      if (accept) begin
         case (req_opcode)
            lare_pkg::OP_SET_AMP: begin
               release_level_in = 17'd0;
               if (req_amplitude_value == 16'sd0) begin
                  release_level_in = EnvOne;
               end else begin
                  if (amplitude_ff == 16'sd0) attack_level_in = EnvOne;
                  amplitude_in = req_amplitude_value;
               end
            end
            lare_pkg::OP_STOP: begin
               if (release_level_ff == 17'd0) release_level_in = EnvOne;
            end
            lare_pkg::OP_TICK: begin
               active_in = amp_positive;
               if (amp_positive) begin
                  if (release_level_ff != 17'd0) begin
                     if (release_diff <= $signed(18'(lare_pkg::RELEASE_CUTOFF))) begin
                        amplitude_in     = 16'sd0;
                        attack_level_in  = EnvOne;
                        release_level_in = 17'd0;
                        active_in        = 1'b0;
                     end else begin
                        release_level_in = release_diff[16:0];
                     end
                  end else begin
                     attack_level_in = attack_next;
                  end
               end
               count_in  = 5'd0;
               acc_in    = 48'sd0;
               mcand_in  = {16'd0, tick_amp};
               mplier_in = tick_env;
               wave_in   = req_wave_sample;
            end
            default: ;
         endcase
      end

      case (state_ff)
         lare_pkg::ST_MUL_ENV: begin
            acc_in    = acc_step;
            mplier_in = {mplier_ff[15:0], 1'b0};
            count_in  = count_ff + 5'd1;
            // hand amplitude * envelope over as the multiplicand of the sample pass
            if (count_ff == 5'(lare_pkg::ENV_BITS - 1)) begin
               count_in  = 5'd0;
               acc_in    = 48'sd0;
               mcand_in  = acc_step[30:0];
               mplier_in = {wave_ff, 1'b0};
            end
         end
         lare_pkg::ST_MUL_WAVE: begin
            acc_in    = acc_step;
            mplier_in = {mplier_ff[15:0], 1'b0};
            count_in  = count_ff + 5'd1;
         end
         lare_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               voice_in     = active_ff;
               if (!quotient[16] && quotient[15]) begin
                  audio_in = 16'sh7fff;
               end else if (quotient[16] && !quotient[15]) begin
                  audio_in = -16'sh8000;
               end else begin
                  audio_in = quotient[15:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lare_pkg::ST_IDLE;
         attack_step_ff   <= 17'(lare_pkg::STEP_RESET);
         release_step_ff  <= 17'(lare_pkg::STEP_RESET);
         amplitude_ff     <= 16'sd0;
         attack_level_ff  <= EnvOne;
         release_level_ff <= 17'd0;
         count_ff         <= 5'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         attack_step_ff   <= attack_step_in;
         release_step_ff  <= release_step_in;
         amplitude_ff     <= amplitude_in;
         attack_level_ff  <= attack_level_in;
         release_level_ff <= release_level_in;
         count_ff         <= count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      wave_ff   <= wave_in;
      active_ff <= active_in;
      audio_ff  <= audio_in;
      voice_ff  <= voice_in;
   end

   // a tick transaction starts the envelope pass
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == lare_pkg::OP_TICK)) |=> (state_ff == lare_pkg::ST_MUL_ENV))
      else $error("tick did not start multiply");

   // a finished product is loaded into a free output register and the unit goes idle
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == lare_pkg::ST_DONE) && out_free)
      |=> (rsp_valid_ff && (state_ff == lare_pkg::ST_IDLE)))
      else $error("result not delivered from done state");

   // a running release always sits above the cutoff
   a_release_range: assert property (@(posedge clock) disable iff (reset)
      (release_level_ff != 17'd0) |->
      ((release_level_ff > 17'(lare_pkg::RELEASE_CUTOFF)) && (release_level_ff <= EnvOne)))
      else $error("release level out of range");

   // ramp state and steps never exceed full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (attack_level_ff <= EnvOne) && (attack_step_ff <= EnvOne) && (release_step_ff <= EnvOne))
      else $error("attack level or step above full scale");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

typedef struct packed {
   logic signed [15:0] audio;
   logic               active;
} gated_sample_type;

class envelope_tracker;
   logic [16:0]        attack_step;
   logic [16:0]        release_step;
   logic signed [15:0] amplitude;
   logic [16:0]        attack_level;
   logic [16:0]        release_level;
   gated_sample_type   expected_samples[$];
   int                 mismatches;

   function new();
      attack_step   = 17'(lare_pkg::STEP_RESET);
      release_step  = 17'(lare_pkg::STEP_RESET);
      amplitude     = '0;
      attack_level  = 17'(lare_pkg::ENV_ONE);
      release_level = '0;
      mismatches    = 0;
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   // steps above 1.0 clamp to 1.0
   function void write_reg(logic [1:0] idx, logic [16:0] data);
      logic [16:0] clamped;
      clamped = (data > lare_pkg::ENV_ONE) ? 17'(lare_pkg::ENV_ONE) : data;
      if (idx == lare_pkg::REG_ATTACK_STEP) attack_step = clamped;
      else if (idx == lare_pkg::REG_RELEASE_STEP) release_step = clamped;
   endfunction

   // amplitude Q0.15 * sample * envelope Q1.16, floor shift by 31, saturate
   function logic signed [15:0] gate_sample(int amp, int wave, int env);
      longint prod;
      prod = longint'(amp) * longint'(wave) * longint'(env);
      prod = prod >>> 31;
      if (prod > 32767) prod = 32767;
      else if (prod < -32768) prod = -32768;
      return prod[15:0];
   endfunction

   function void take_command(lare_pkg::opcode_type op, logic signed [15:0] amp,
                              logic signed [15:0] wave);
      int               nxt;
      gated_sample_type s;
      case (op)
         lare_pkg::OP_SET_AMP: begin
            release_level = '0;
            if (amp == 0) begin
               release_level = 17'(lare_pkg::ENV_ONE);
            end else begin
               if (amplitude == 0) attack_level = 17'(lare_pkg::ENV_ONE);
               amplitude = amp;
            end
         end
         lare_pkg::OP_STOP: begin
            if (release_level == 0) release_level = 17'(lare_pkg::ENV_ONE);
         end
         lare_pkg::OP_TICK: begin
            s.audio = '0;
            if (amplitude > 0) begin
               if (release_level != 0) begin
                  s.audio = gate_sample(amplitude, wave, release_level);
                  nxt = int'(release_level) - int'(release_step);
                  if (nxt <= lare_pkg::RELEASE_CUTOFF) begin
                     amplitude     = '0;
                     attack_level  = 17'(lare_pkg::ENV_ONE);
                     release_level = '0;
                  end else begin
                     release_level = 17'(nxt);
                  end
               end else begin
                  nxt = int'(attack_level) - int'(attack_step);
                  attack_level = (nxt <= lare_pkg::ATTACK_SNAP) ? 17'd0 : 17'(nxt);
                  s.audio = gate_sample(amplitude, wave,
                                        lare_pkg::ENV_ONE - int'(attack_level));
               end
            end
            s.active = (amplitude > 0);
            expected_samples.push_back(s);
         end
         default: ;
      endcase
   endfunction

   function void compare_sample(logic signed [15:0] audio, logic active);
      gated_sample_type want;
      if (expected_samples.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: audio %0d active %0b", audio, active);
         return;
      end
      want = expected_samples.pop_front();
      if (audio !== want.audio || active !== want.active) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: audio %0d active %0b, expected audio %0d active %0b",
                     audio, active, want.audio, want.active);
      end
   endfunction
endclass

module tb;

   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 108;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   lare_pkg::opcode_type req_opcode = lare_pkg::OP_TICK;
   logic signed [15:0]   req_amplitude_value = '0;
   logic signed [15:0]   req_wave_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [15:0]   rsp_audio_out;
   logic                 rsp_voice_active;
   logic                 csr_write_enable = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [16:0]          csr_write_data = '0;

   envelope_tracker tracker;
   int sender_idle = 27;
   int receiver_idle = 49;
   int items_sent = 0;
   int cycle_count = 0;

   int unsigned attack_cfg [NUM_PHASES] = '{3000, 7, 65536, 131071, 0, 12000, 1, 0};
   int unsigned release_cfg[NUM_PHASES] = '{5000, 7, 65536, 70000, 9000, 0, 65535, 0};

   linear_attack_release_envelope_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_amplitude_value(req_amplitude_value),
      .req_wave_sample    (req_wave_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_audio_out      (rsp_audio_out),
      .rsp_voice_active   (rsp_voice_active),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.compare_sample(rsp_audio_out, rsp_voice_active);
      rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drive_item(input lare_pkg::opcode_type op,
                             input logic signed [15:0] amp,
                             input logic signed [15:0] wave);
      int gap;
      if (items_sent < 315) begin
         sender_idle = 27;
         receiver_idle = 49;
      end else if (items_sent < 630) begin
         sender_idle = 49;
         receiver_idle = 27;
      end else begin
         sender_idle = 0;
         receiver_idle = 0;
      end
      gap = 0;
      if ($urandom_range(99) < sender_idle)
         gap = $urandom_range(($urandom_range(3) == 0) ? 45 : 3, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_amplitude_value <= amp;
      req_wave_sample     <= wave;
      do @(posedge clock); while (!req_ready);
      tracker.take_command(op, amp, wave);
      items_sent++;
   endtask

   // drop valid and hold until every result is back and the block has settled
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                   ph;
      int                   k;
      int                   r;
      lare_pkg::opcode_type op;
      logic signed [15:0]   amp;
      logic signed [15:0]   wave;

      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_csr(lare_pkg::REG_ATTACK_STEP, 17'd20000);
      write_csr(lare_pkg::REG_RELEASE_STEP, 17'd30000);

      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd32767);       // silent voice
      drive_item(lare_pkg::OP_NONE, -16'sd1, -16'sd1);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd32767, 16'sd0);
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd32767);
      drive_item(lare_pkg::OP_TICK, 16'sd0, -16'sd32768);
      drive_item(lare_pkg::OP_TICK, -16'sd32768, 16'sd1);
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd32767);       // attack snaps to full
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd0);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd0, 16'sd0);        // release begins
      drive_item(lare_pkg::OP_TICK, 16'sd0, -16'sd32768);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd0, 16'sd0);        // release restarts
      drive_item(lare_pkg::OP_STOP, 16'sd0, 16'sd0);
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd12345);
      drive_item(lare_pkg::OP_TICK, 16'sd0, -16'sd1);
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd32767);       // release ends
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd1000);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd20000, 16'sd0);    // attack restarts
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd20000);
      drive_item(lare_pkg::OP_SET_AMP, -16'sd32768, 16'sd0);   // negative amplitude
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd32767);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd1, 16'sd0);
      drive_item(lare_pkg::OP_TICK, 16'sd0, -16'sd1);
      drive_item(lare_pkg::OP_STOP, 16'sd0, 16'sd0);
      drive_item(lare_pkg::OP_SET_AMP, 16'sd100, 16'sd0);      // cancel release
      drive_item(lare_pkg::OP_TICK, 16'sd0, 16'sd5000);
      hold_until_drained();

      write_csr(CSR_UNMAPPED, 17'h1FFFF);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1) begin
            attack_cfg[ph]  = $urandom_range(30000, 200);
            release_cfg[ph] = $urandom_range(30000, 200);
         end
         write_csr(lare_pkg::REG_ATTACK_STEP, 17'(attack_cfg[ph]));
         write_csr(lare_pkg::REG_RELEASE_STEP, 17'(release_cfg[ph]));
         k = 0;
         while (k < PHASE_ITEMS) begin
            if (ph == 1 && k == 60) hold_until_drained();
            r = $urandom_range(99);
            if (r < 66) op = lare_pkg::OP_TICK;
            else if (r < 82) op = lare_pkg::OP_SET_AMP;
            else if (r < 94) op = lare_pkg::OP_STOP;
            else op = lare_pkg::OP_NONE;
            r = $urandom_range(99);
            if (r < 55) amp = 16'($urandom_range(32767, 1));
            else if (r < 75) amp = '0;
            else if (r < 90) amp = {1'b1, 15'($urandom)};
            else amp = ($urandom_range(1) == 0) ? 16'sd32767 : -16'sd32768;
            r = $urandom_range(99);
            if (r < 5) wave = 16'sd32767;
            else if (r < 10) wave = -16'sd32768;
            else wave = 16'($urandom);
            drive_item(op, amp, wave);
            if (op != lare_pkg::OP_NONE) k++;
         end
         hold_until_drained();
      end

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
